[rtl/core/amlc_pkg.sv]
// ----------------------------------------------------------------------------
// amlc_pkg
// Shared constants and lookup tables for the log-compressing audio mixer.
// ----------------------------------------------------------------------------
package amlc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int THR_W     = 5;
   localparam int CHAN_W    = 4;
   localparam int CSR_W     = 5;
   localparam int ALPHA_W   = 14;
   localparam int FRAC_W    = 16;
   localparam int IDX_MAX   = 19;

   // register indexes on the csr port
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_CHANNELS  = 1'b1;

   localparam logic [THR_W-1:0]  THR_RESET  = 5'd12;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd2;

   // alpha in hundredths, paired with threshold index*0.05
   function automatic logic [ALPHA_W-1:0] alpha_lut(input logic [THR_W-1:0] idx);
      logic [ALPHA_W-1:0] a;
      case (idx)
         5'd0:    a = 14'd251;
         5'd1:    a = 14'd267;
         5'd2:    a = 14'd284;
         5'd3:    a = 14'd304;
         5'd4:    a = 14'd326;
         5'd5:    a = 14'd352;
         5'd6:    a = 14'd382;
         5'd7:    a = 14'd417;
         5'd8:    a = 14'd459;
         5'd9:    a = 14'd509;
         5'd10:   a = 14'd571;
         5'd11:   a = 14'd649;
         5'd12:   a = 14'd748;
         5'd13:   a = 14'd881;
         5'd14:   a = 14'd1063;
         5'd15:   a = 14'd1330;
         5'd16:   a = 14'd1751;
         5'd17:   a = 14'd2497;
         5'd18:   a = 14'd4115;
         default: a = 14'd9609;
      endcase
      return a;
   endfunction

   // alpha in Q.16, floor(hundredths * 65536 / 100)
   function automatic logic [22:0] alpha_q16_lut(input logic [THR_W-1:0] idx);
      logic [22:0] a;
      case (idx)
         5'd0:    a = 23'd164495;
         5'd1:    a = 23'd174981;
         5'd2:    a = 23'd186122;
         5'd3:    a = 23'd199229;
         5'd4:    a = 23'd213647;
         5'd5:    a = 23'd230686;
         5'd6:    a = 23'd250347;
         5'd7:    a = 23'd273285;
         5'd8:    a = 23'd300810;
         5'd9:    a = 23'd333578;
         5'd10:   a = 23'd374210;
         5'd11:   a = 23'd425328;
         5'd12:   a = 23'd490209;
         5'd13:   a = 23'd577372;
         5'd14:   a = 23'd696647;
         5'd15:   a = 23'd871628;
         5'd16:   a = 23'd1147535;
         5'd17:   a = 23'd1636433;
         5'd18:   a = 23'd2696806;
         default: a = 23'd6297354;
      endcase
      return a;
   endfunction

   // log2(1 + i/32) in Q.16
   function automatic logic [16:0] log2_lut(input logic [5:0] i);
      logic [16:0] v;
      case (i)
         6'd0:    v = 17'd0;
         6'd1:    v = 17'd2909;
         6'd2:    v = 17'd5732;
         6'd3:    v = 17'd8473;
         6'd4:    v = 17'd11136;
         6'd5:    v = 17'd13727;
         6'd6:    v = 17'd16248;
         6'd7:    v = 17'd18704;
         6'd8:    v = 17'd21098;
         6'd9:    v = 17'd23433;
         6'd10:   v = 17'd25711;
         6'd11:   v = 17'd27936;
         6'd12:   v = 17'd30109;
         6'd13:   v = 17'd32234;
         6'd14:   v = 17'd34312;
         6'd15:   v = 17'd36346;
         6'd16:   v = 17'd38336;
         6'd17:   v = 17'd40285;
         6'd18:   v = 17'd42196;
         6'd19:   v = 17'd44068;
         6'd20:   v = 17'd45904;
         6'd21:   v = 17'd47705;
         6'd22:   v = 17'd49472;
         6'd23:   v = 17'd51207;
         6'd24:   v = 17'd52911;
         6'd25:   v = 17'd54584;
         6'd26:   v = 17'd56229;
         6'd27:   v = 17'd57845;
         6'd28:   v = 17'd59434;
         6'd29:   v = 17'd60997;
         6'd30:   v = 17'd62534;
         6'd31:   v = 17'd64047;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/amlc_front.sv]
// ----------------------------------------------------------------------------
// amlc_front
// Accumulates channel samples into a frame sum and queues finished frames.
// ----------------------------------------------------------------------------
module amlc_front #(
   parameter int MAX_CH = 8,
   parameter int CNT_W  = 4,
   parameter int SUM_W  = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [amlc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [amlc_pkg::THR_W-1:0]        thr,
   input  logic [amlc_pkg::CHAN_W-1:0]       chan,
   input  logic                              q_full,
   output logic                              push,
   output logic [SUM_W+amlc_pkg::THR_W+CNT_W-1:0] push_data
);

   logic signed [SUM_W-1:0]     sum_ff, sum_in, sum_nx;
   logic [CNT_W-1:0]            pos_ff, pos_in;
   logic [CNT_W-1:0]            ceff;
   logic [amlc_pkg::THR_W-1:0]  idx_eff;
   logic                        accept, last;

   always_comb begin
      if (chan == '0) begin
         ceff = CNT_W'(1);
      end else if (32'(chan) > MAX_CH) begin
         ceff = CNT_W'(MAX_CH);
      end else begin
         ceff = CNT_W'(chan);
      end
      if (32'(thr) > amlc_pkg::IDX_MAX) begin
         idx_eff = amlc_pkg::THR_W'(amlc_pkg::IDX_MAX);
      end else begin
         idx_eff = thr;
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign sum_nx    = sum_ff + SUM_W'(req_sample);
   assign last      = ({1'b0, pos_ff} + (CNT_W+1)'(1)) >= {1'b0, ceff};
   assign push      = accept & last;
   assign push_data = {sum_nx, idx_eff, ceff};

   always_comb begin
      sum_in = sum_ff;
      pos_in = pos_ff;
      if (accept) begin
         if (last) begin
            sum_in = '0;
            pos_in = '0;
         end else begin
            sum_in = sum_nx;
            pos_in = pos_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         pos_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         pos_ff <= pos_in;
      end
   end

endmodule

[rtl/core/amlc_queue.sv]
// ----------------------------------------------------------------------------
// amlc_queue
// Two-entry frame queue between the accumulator and the compressor.
// ----------------------------------------------------------------------------
module amlc_queue #(
   parameter int W = 29
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         full,
   output logic         empty
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

[rtl/core/amlc_back.sv]
// ----------------------------------------------------------------------------
// amlc_back
// Knee test and log curve: sequencer around one bit-serial divider and one
// shift-normalizing log2 unit, with a registered result word.
// ----------------------------------------------------------------------------
module amlc_back #(
   parameter int CNT_W = 4,
   parameter int SUM_W = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  logic [SUM_W+amlc_pkg::THR_W+CNT_W-1:0] q_data,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [amlc_pkg::SAMPLE_W-1:0] rsp_mixed_sample,
   output logic                                rsp_compressed
);

   localparam int AW   = SUM_W - 1;
   localparam int DFW  = AW + 5;
   localparam int NW   = amlc_pkg::ALPHA_W + DFW + 16;
   localparam int DENW = CNT_W + 28;
   localparam int YW   = NW + 1;
   localparam int LIW  = $clog2(YW);
   localparam int LW   = LIW + 17;
   localparam int FNW  = LW + 5;
   localparam int DVW  = (NW > FNW + 16) ? NW : FNW + 16;
   localparam int DSW  = (DENW > FNW) ? DENW : FNW;
   localparam int DCW  = $clog2(DVW + 1);
   localparam int FW   = 21;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_MUL, S_DIV, S_DIVEND, S_LOG, S_LSEG, S_FNUM, S_MAG, S_DONE
   } state_type;

   typedef enum logic [1:0] {PH_Y, PH_A, PH_F} phase_type;

   state_type                  state_ff;
   phase_type                  phase_ff;
   logic                       neg_ff;
   logic [AW-1:0]              a_ff;
   logic [15:0]                d_ff;
   logic [amlc_pkg::THR_W-1:0] idx_ff;
   logic [CNT_W-1:0]           c_ff;
   logic [15:0]                s16_ff;
   logic [DFW-1:0]             diff_ff;
   logic [22:0]                dd_ff;
   logic [DSW-1:0]             rem_ff, dvs_ff;
   logic [DVW-1:0]             dq_ff;
   logic [DCW-1:0]             dcnt_ff;
   logic [YW-1:0]              lv_ff;
   logic [LIW-1:0]             lcnt_ff;
   logic [LW-1:0]              ly_ff, la_ff;
   logic [FW-1:0]              f_ff;
   logic                       rsp_valid_ff;
   logic [15:0]                rsp_data_ff, res_ff;
   logic                       rsp_comp_ff, comp_ff;

   // frame fields
   logic signed [SUM_W-1:0]    q_sum;
   logic [amlc_pkg::THR_W-1:0] q_idx;
   logic [CNT_W-1:0]           q_c;
   logic [AW-1:0]              q_a;

   // combinational helpers
   logic [amlc_pkg::ALPHA_W-1:0] a100;
   logic [DFW-1:0]             lhs, rhs;
   logic [DSW:0]               trial;
   logic                       qbit;
   logic [4:0]                 seg_i;
   logic [10:0]                seg_lo;
   logic [16:0]                t0, t1;
   logic [22:0]                seg_p;
   logic [LW-1:0]              lres;
   logic [36:0]                mprod;
   logic [20:0]                mag;
   logic [16:0]                magsat;

   assign {q_sum, q_idx, q_c} = q_data;
   assign q_a  = q_sum[SUM_W-1] ? AW'(-q_sum) : AW'(q_sum);
   assign pop  = (state_ff == S_IDLE) && !q_empty;
   assign a100 = amlc_pkg::alpha_lut(idx_ff);
   assign lhs  = DFW'(a_ff) * DFW'(20);
   assign rhs  = DFW'(idx_ff) * DFW'(d_ff);

   assign trial = {rem_ff, dq_ff[DVW-1]};
   assign qbit  = trial >= {1'b0, dvs_ff};

   assign seg_i  = lv_ff[15:11];
   assign seg_lo = lv_ff[10:0];
   assign t0     = amlc_pkg::log2_lut({1'b0, seg_i});
   assign t1     = amlc_pkg::log2_lut({1'b0, seg_i} + 6'd1);
   assign seg_p  = 23'(t1 - t0) * 23'(seg_lo);
   assign lres   = LW'({lcnt_ff, 16'd0}) + LW'(t0) + LW'(seg_p[22:11]);

   assign mprod = 37'(d_ff) * 37'(f_ff);
   assign mag   = mprod[36:16];
   always_comb begin
      if (neg_ff) begin
         magsat = (mag > 21'd32768) ? 17'd32768 : mag[16:0];
      end else begin
         magsat = (mag > 21'd32767) ? 17'd32767 : mag[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_Y;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_DONE reloads the word itself when the current one is taken
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  neg_ff   <= q_sum[SUM_W-1];
                  a_ff     <= q_a;
                  d_ff     <= q_sum[SUM_W-1] ? 16'd32768 : 16'd32767;
                  idx_ff   <= q_idx;
                  c_ff     <= q_c;
                  s16_ff   <= q_sum[15:0];
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               if (lhs <= rhs) begin
                  res_ff   <= s16_ff;
                  comp_ff  <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  diff_ff  <= lhs - rhs;
                  dd_ff    <= 23'(d_ff) * 23'd100;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               dq_ff    <= DVW'({(amlc_pkg::ALPHA_W+DFW)'(a100) *
                                 (amlc_pkg::ALPHA_W+DFW)'(diff_ff), 16'd0});
               dvs_ff   <= DSW'(DENW'(dd_ff) *
                                DENW'(DENW'(c_ff) * DENW'(20) - DENW'(idx_ff)));
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               phase_ff <= PH_Y;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= qbit ? DSW'(trial - {1'b0, dvs_ff}) : DSW'(trial);
               dq_ff   <= {dq_ff[DVW-2:0], qbit};
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DCW'(DVW - 1)) begin
                  state_ff <= S_DIVEND;
               end
            end
            S_DIVEND: begin
               case (phase_ff)
                  PH_F: begin
                     f_ff     <= (|dq_ff[DVW-1:FW]) ? {FW{1'b1}} : dq_ff[FW-1:0];
                     state_ff <= S_MAG;
                  end
                  default: begin
                     lv_ff    <= YW'(dq_ff) + YW'(65536);
                     lcnt_ff  <= '0;
                     state_ff <= S_LOG;
                  end
               endcase
            end
            S_LOG: begin
               // normalize to [1,2) one bit per cycle
               if (|lv_ff[YW-1:17]) begin
                  lv_ff   <= lv_ff >> 1;
                  lcnt_ff <= lcnt_ff + LIW'(1);
               end else begin
                  state_ff <= S_LSEG;
               end
            end
            S_LSEG: begin
               if (phase_ff == PH_Y) begin
                  ly_ff    <= lres;
                  // 1 + alpha in Q.16 comes straight from the table
                  lv_ff    <= YW'(amlc_pkg::alpha_q16_lut(idx_ff)) + YW'(65536);
                  lcnt_ff  <= '0;
                  phase_ff <= PH_A;
                  state_ff <= S_LOG;
               end else begin
                  la_ff    <= lres;
                  state_ff <= S_FNUM;
               end
            end
            S_FNUM: begin
               dq_ff    <= DVW'({FNW'(idx_ff) * FNW'(la_ff) +
                                 FNW'(5'd20 - idx_ff) * FNW'(ly_ff), 16'd0});
               dvs_ff   <= DSW'(FNW'(la_ff) * FNW'(20));
               rem_ff   <= '0;
               dcnt_ff  <= '0;
               phase_ff <= PH_F;
               state_ff <= S_DIV;
            end
            S_MAG: begin
               res_ff   <= neg_ff ? 16'(17'd65536 - magsat) : magsat[15:0];
               comp_ff  <= 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  rsp_comp_ff  <= comp_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_data_ff;
   assign rsp_compressed   = rsp_comp_ff;

endmodule

[rtl/core/audio_mix_log_compressor.sv]
// ----------------------------------------------------------------------------
// audio_mix_log_compressor
// Sums channel samples into frames and applies a logarithmic knee curve.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | notes
//  --------+-----------------------------------------+-----+-------------------
//  req     | req_valid req_stall req_sample          | in  | one sample a word
//  rsp     | rsp_valid rsp_stall rsp_mixed_sample    | out | one word a frame
//          | rsp_compressed                          |     |
//  csr     | csr_we csr_index csr_wdata              | in  | write only
//
//  The front end takes one sample word per cycle; it stalls only when both
//  queue slots hold finished frames.
//  Below the knee a frame goes from the knee test straight to the output
//  word; above it, it takes two passes of a one-bit-per-cycle divider
//  over DVW bits (DVW = 54 at MAX_CH = 8) plus the normalize shifts of
//  two log2 passes.
//  Reset (synchronous) clears the frame sum, queue, sequencer and output;
//  threshold index returns to 12 and channel count to 2.
//  A held rsp word keeps the back end in its last step; samples keep flowing
//  into the queue until both of its slots hold finished frames.
//
module audio_mix_log_compressor #(
   parameter int MAX_CH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [amlc_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [amlc_pkg::SAMPLE_W-1:0] rsp_mixed_sample,
   output logic                                 rsp_compressed,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [amlc_pkg::CSR_W-1:0]           csr_wdata
);

   // count must hold MAX_CH itself; sum holds MAX_CH full-scale samples
   localparam int CNT_W = $clog2(MAX_CH + 1);
   localparam int SUM_W = 17 + $clog2(MAX_CH);
   localparam int QW    = SUM_W + amlc_pkg::THR_W + CNT_W;

   logic [amlc_pkg::THR_W-1:0]  thr_ff;
   logic [amlc_pkg::CHAN_W-1:0] chan_ff;

   logic          q_push, q_pop, q_full, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;

   // configuration registers, raw; clamping happens when a frame closes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= amlc_pkg::THR_RESET;
         chan_ff <= amlc_pkg::CHAN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            amlc_pkg::CSR_THRESHOLD: thr_ff  <= csr_wdata[amlc_pkg::THR_W-1:0];
            amlc_pkg::CSR_CHANNELS:  chan_ff <= csr_wdata[amlc_pkg::CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front end: accumulate samples, push finished frames
   amlc_front #(
      .MAX_CH (MAX_CH),
      .CNT_W  (CNT_W),
      .SUM_W  (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .thr        (thr_ff),
      .chan       (chan_ff),
      .q_full     (q_full),
      .push       (q_push),
      .push_data  (q_wdata)
   );

   // frame queue decouples the two sides
   amlc_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back end: knee test, divide, log2, curve, output register
   amlc_back #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_rdata),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_compressed   (rsp_compressed)
   );

endmodule
